// ===== rtl/bvcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvcd_pkg
// Shared types and constants of the base vote correction decider: tally
// widths, transfer payloads, configuration state and register indexes.
// ----------------------------------------------------------------------------
package bvcd_pkg;

  localparam int TALLY_BITS    = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 1;
  localparam int STRONG_VOTES  = 6;
  localparam int SUB_COUNT     = 5;
  localparam int INS_COUNT     = 4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_HAPLO_VOTES = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HAPLO_CHECK_ON  = 1'd1;

  localparam logic [2:0] CHANGE_DELETE = 3'd0;
  localparam logic [1:0] INSERT_A      = 2'd0;

  localparam logic [15:0] MIN_HAPLO_RESET = 16'd3;
  localparam logic        HAPLO_ON_RESET  = 1'b1;

  typedef logic [TALLY_BITS-1:0] tally_t;

  typedef struct packed {
    logic [2:0] current_base;
    tally_t     confirmed_votes;
    tally_t     delete_votes;
    tally_t     sub_a_votes;
    tally_t     sub_c_votes;
    tally_t     sub_g_votes;
    tally_t     sub_t_votes;
    tally_t     no_insert_votes;
    tally_t     ins_a_votes;
    tally_t     ins_c_votes;
    tally_t     ins_g_votes;
    tally_t     ins_t_votes;
  } in_item_t;

  typedef struct packed {
    logic       change_valid;
    logic [2:0] change_type;
    logic       insert_valid;
    logic [1:0] insert_type;
  } out_item_t;

  typedef struct packed {
    logic [15:0] min_haplo_votes;
    logic        haplo_check_on;
  } cfg_t;

endpackage

// ===== rtl/bvcd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvcd_cfg_regs
// Configuration register file: haplotype vote threshold and haplotype check
// enable, written through a plain write port.
// ----------------------------------------------------------------------------
module bvcd_cfg_regs
  import bvcd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_HAPLO_VOTES: cfg_nxt.min_haplo_votes = cfg_wdata[15:0];
        CFG_HAPLO_CHECK_ON:  cfg_nxt.haplo_check_on  = cfg_wdata[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_haplo_votes <= MIN_HAPLO_RESET;
      cfg_r.haplo_check_on  <= HAPLO_ON_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/bvcd_vote_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvcd_vote_eval
// One vote decision: strict maximum (first wins ties), total, significant
// count and the shared acceptance test against the guard tally.
// ----------------------------------------------------------------------------
module bvcd_vote_eval
  import bvcd_pkg::*;
#(
  parameter int N = 5
) (
  input  logic [N-1:0][TALLY_BITS-1:0] tally,
  input  tally_t                       guard,
  input  cfg_t                         cfg,
  output logic [$clog2(N)-1:0]         win_idx,
  output logic                         accept
);

  localparam int IDX_W   = $clog2(N);
  localparam int SUM_W   = TALLY_BITS + $clog2(N);
  localparam int CNT_W   = $clog2(N + 1);
  localparam int CMP_W   = (TALLY_BITS > 16) ? TALLY_BITS : 16;

  tally_t           best;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] sig_cnt;
  logic [SUM_W:0]   best_x2;

  always_comb begin
    best    = tally[0];
    win_idx = '0;
    sum     = '0;
    sig_cnt = '0;
    for (int k = 0; k < N; k++) begin
      if (tally[k] > best) begin
        best    = tally[k];
        win_idx = IDX_W'(k);
      end
      sum = sum + SUM_W'(tally[k]);
      if (CMP_W'(tally[k]) >= CMP_W'(cfg.min_haplo_votes)) begin
        sig_cnt = sig_cnt + CNT_W'(1);
      end
    end
  end

  assign best_x2 = (SUM_W + 1)'(best) << 1;

  always_comb begin
    accept = 1'b1;
    if (guard >= TALLY_BITS'(2)) begin
      accept = 1'b0;
    end
    if (sum <= SUM_W'(1)) begin
      accept = 1'b0;
    end
    if (best_x2 <= (SUM_W + 1)'(sum)) begin
      accept = 1'b0;
    end
    if (sig_cnt >= CNT_W'(2) && cfg.haplo_check_on) begin
      accept = 1'b0;
    end
    if (guard == TALLY_BITS'(1) && best <= TALLY_BITS'(STRONG_VOTES)) begin
      accept = 1'b0;
    end
  end

endmodule

// ===== rtl/base_vote_correction_decider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base_vote_correction_decider
// Decides per read position whether to emit a substitution or deletion and
// whether to emit an insertion, from the position's vote tallies.
//
//   channel  ports                    payload
//   input    in_valid / in_ready      in_data  (in_item_t)
//   result   out_valid / out_ready    out_data (out_item_t)
//   config   cfg_we                   cfg_index, cfg_wdata
//
// One item per cycle sustained while results are taken; an input transfer
// reaches result valid through the input register, decision logic and result register.
// Reset is synchronous, active low; it empties both stages and loads the
// register defaults.
// A stalled result holds the result register; the input register keeps
// filling until both stages are occupied.
// ----------------------------------------------------------------------------
module base_vote_correction_decider
  import bvcd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t      cfg;
  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      s2_valid_r;
  out_item_t s2_data_r;
  out_item_t s2_data_nxt;
  logic      s2_load;

  logic [$clog2(SUB_COUNT)-1:0] sub_win;
  logic [$clog2(INS_COUNT)-1:0] ins_win;
  logic                         sub_accept;
  logic                         ins_accept;
  logic                         differs;

  bvcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bvcd_vote_eval #(.N(SUB_COUNT)) u_sub_eval (
    .tally   ({s1_data_r.sub_t_votes, s1_data_r.sub_g_votes, s1_data_r.sub_c_votes,
               s1_data_r.sub_a_votes, s1_data_r.delete_votes}),
    .guard   (s1_data_r.confirmed_votes),
    .cfg     (cfg),
    .win_idx (sub_win),
    .accept  (sub_accept)
  );

  bvcd_vote_eval #(.N(INS_COUNT)) u_ins_eval (
    .tally   ({s1_data_r.ins_t_votes, s1_data_r.ins_g_votes, s1_data_r.ins_c_votes,
               s1_data_r.ins_a_votes}),
    .guard   (s1_data_r.no_insert_votes),
    .cfg     (cfg),
    .win_idx (ins_win),
    .accept  (ins_accept)
  );

  // deletion always differs; any other winner must not match the base
  assign differs = (sub_win == CHANGE_DELETE) ||
                   (s1_data_r.current_base != 3'(sub_win - 3'd1));

  always_comb begin
    s2_data_nxt.change_valid = sub_accept && differs;
    s2_data_nxt.change_type  = (sub_accept && differs) ? 3'(sub_win) : CHANGE_DELETE;
    s2_data_nxt.insert_valid = ins_accept;
    s2_data_nxt.insert_type  = ins_accept ? 2'(ins_win) : INSERT_A;
  end

  assign s2_load  = !s2_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_load) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (s2_load && s1_valid_r) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_data_r;

`ifndef SYNTHESIS
  a_change_type_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.change_valid |-> out_data.change_type == CHANGE_DELETE)
    else $error("change_type set without change_valid");

  a_insert_type_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.insert_valid |-> out_data.insert_type == INSERT_A)
    else $error("insert_type set without insert_valid");

  a_change_type_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.change_type <= 3'd4)
    else $error("change_type out of range");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_valid_r || out_ready |-> in_ready)
    else $error("input stalled while result stage is free");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_load |=> s2_valid_r)
    else $error("decision lost between stages");
`endif

endmodule

// ===== tb/base_vote_correction_decider_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base_vote_correction_decider_tb
// Self-checking bench for the base vote correction decider. Position tallies
// go in through the input channel; a built-in predictor works out the change
// and insert decision for every accepted transfer and queues it. Each result
// transfer is compared field by field with the oldest queued decision.
// Directed corner cases and haplotype register settings come first, then
// shaped random traffic under several register settings and idle/stall mixes,
// and finally a long result stall that backs the pipeline up.
// ----------------------------------------------------------------------------
module base_vote_correction_decider_tb;
  import bvcd_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 5;
  localparam int DRAIN_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 48;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BLOCK_ITEMS    = 160;
  localparam int MAX_PRINTS     = 20;

  localparam logic [2:0] BASE_A     = 3'd0;
  localparam logic [2:0] BASE_C     = 3'd1;
  localparam logic [2:0] BASE_G     = 3'd2;
  localparam logic [2:0] BASE_T     = 3'd3;
  localparam logic [2:0] BASE_OTHER = 3'd4;
  localparam logic [2:0] BASE_UNUSED_LO = 3'd5;
  localparam logic [2:0] BASE_UNUSED_HI = 3'd7;

  localparam tally_t TALLY_MAX = '1;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  in_item_t                 in_data;
  logic                     out_valid;
  logic                     out_ready;
  out_item_t                out_data;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  // predictor copy of the registers
  logic [15:0] min_haplo_cfg;
  logic        haplo_on_cfg;

  out_item_t decision_q[$];

  int idle_pct;
  int stall_pct;
  bit hold_req;
  int mismatches;
  int positions_sent;
  int results_checked;
  int changes_seen;
  int inserts_seen;
  int settings_used;

  base_vote_correction_decider i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit tally_vote(input tally_t [4:0] votes, input int count,
                                    input tally_t guard, output logic [2:0] winner);
    tally_t      best;
    logic [19:0] total;
    int          sig_cnt;
    best    = votes[0];
    winner  = 3'd0;
    total   = '0;
    sig_cnt = 0;
    // strict maximum, earlier entry keeps a tie
    for (int k = 0; k < count; k++) begin
      if (votes[k] > best) begin
        best   = votes[k];
        winner = 3'(k);
      end
      total = total + 20'(votes[k]);
      if (votes[k] >= min_haplo_cfg) sig_cnt++;
    end
    if (guard >= 2) return 1'b0;
    if (total <= 1) return 1'b0;
    if ((2 * best) <= total) return 1'b0;
    if (sig_cnt >= 2 && haplo_on_cfg) return 1'b0;
    if (guard == 1 && best <= STRONG_VOTES) return 1'b0;
    return 1'b1;
  endfunction

  function automatic out_item_t predict_decision(input in_item_t it);
    out_item_t  res;
    logic [2:0] win;
    res.change_valid = 1'b0;
    res.change_type  = CHANGE_DELETE;
    res.insert_valid = 1'b0;
    res.insert_type  = INSERT_A;
    if (tally_vote({it.sub_t_votes, it.sub_g_votes, it.sub_c_votes, it.sub_a_votes,
                    it.delete_votes}, SUB_COUNT, it.confirmed_votes, win)) begin
      // substitution code n stands for base n-1
      if (win == CHANGE_DELETE || it.current_base != win - 3'd1) begin
        res.change_valid = 1'b1;
        res.change_type  = win;
      end
    end
    if (tally_vote({tally_t'(0), it.ins_t_votes, it.ins_g_votes, it.ins_c_votes,
                    it.ins_a_votes}, INS_COUNT, it.no_insert_votes, win)) begin
      res.insert_valid = 1'b1;
      res.insert_type  = win[1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic in_item_t make_position(
    input logic [2:0] base, input tally_t conf, input tally_t del, input tally_t sa,
    input tally_t sc, input tally_t sg, input tally_t st, input tally_t noins,
    input tally_t ia, input tally_t ic, input tally_t ig, input tally_t itv);
    in_item_t it;
    it.current_base    = base;
    it.confirmed_votes = conf;
    it.delete_votes    = del;
    it.sub_a_votes     = sa;
    it.sub_c_votes     = sc;
    it.sub_g_votes     = sg;
    it.sub_t_votes     = st;
    it.no_insert_votes = noins;
    it.ins_a_votes     = ia;
    it.ins_c_votes     = ic;
    it.ins_g_votes     = ig;
    it.ins_t_votes     = itv;
    return it;
  endfunction

  function automatic tally_t random_tally();
    case ($urandom_range(3))
      0:       return tally_t'($urandom_range(3));
      1:       return tally_t'($urandom_range(15));
      2:       return tally_t'($urandom_range(255));
      default: return tally_t'($urandom_range(65535));
    endcase
  endfunction

  function automatic tally_t random_minor();
    if ($urandom_range(9) < 7) return tally_t'($urandom_range(2));
    return random_tally();
  endfunction

  function automatic tally_t random_guard();
    if ($urandom_range(9) < 8) return tally_t'($urandom_range(2));
    return random_tally();
  endfunction

  function automatic in_item_t random_position();
    in_item_t     it;
    logic [191:0] noise;
    tally_t [4:0] subs;
    tally_t [3:0] inss;
    int           lead;
    if ($urandom_range(99) < 15) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it    = noise[$bits(in_item_t)-1:0];
      return it;
    end
    // one dominant tally per decision, the rest mostly near zero
    lead = $urandom_range(SUB_COUNT - 1);
    for (int k = 0; k < SUB_COUNT; k++) subs[k] = (k == lead) ? random_tally() : random_minor();
    lead = $urandom_range(INS_COUNT - 1);
    for (int k = 0; k < INS_COUNT; k++) inss[k] = (k == lead) ? random_tally() : random_minor();
    return make_position(3'($urandom_range(7)), random_guard(), subs[0], subs[1], subs[2],
                         subs[3], subs[4], random_guard(), inss[0], inss[1], inss[2], inss[3]);
  endfunction

  task automatic send_item(input in_item_t item);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decision_q.push_back(predict_decision(item));
    positions_sent++;
  endtask

  // wait for the pipeline to empty with the input idle
  task automatic settle();
    in_valid <= 1'b0;
    while (decision_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_HAPLO_VOTES) min_haplo_cfg = value;
    else if (idx == CFG_HAPLO_CHECK_ON) haplo_on_cfg = value[0];
  endtask

  task automatic apply_settings(input logic [15:0] min_votes, input logic check_on);
    settle();
    write_register(CFG_MIN_HAPLO_VOTES, min_votes);
    // upper bits of the enable write carry junk
    write_register(CFG_HAPLO_CHECK_ON, {15'($urandom), check_on});
    settings_used++;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [3:0] want,
                                 input logic [3:0] got);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t ns  %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  initial begin : receiver
    int held;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        held = 0;
        while (held < HOLD_CYCLES) begin
          out_ready <= 1'b0;
          held++;
          @(posedge clk);
        end
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : result_checker
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (decision_q.size() == 0) begin
          report_mismatch("result transfer with no position pending", 4'd0,
                          {out_data.change_valid, out_data.change_type});
        end else begin
          want = decision_q.pop_front();
          results_checked++;
          if (want.change_valid) changes_seen++;
          if (want.insert_valid) inserts_seen++;
          if (out_data.change_valid !== want.change_valid)
            report_mismatch("change_valid", 4'(want.change_valid),
                            4'(out_data.change_valid));
          if (out_data.change_type !== want.change_type)
            report_mismatch("change_type", 4'(want.change_type),
                            4'(out_data.change_type));
          if (out_data.insert_valid !== want.insert_valid)
            report_mismatch("insert_valid", 4'(want.insert_valid),
                            4'(out_data.insert_valid));
          if (out_data.insert_type !== want.insert_type)
            report_mismatch("insert_type", 4'(want.insert_type),
                            4'(out_data.insert_type));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("base_vote_correction_decider: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(make_position(BASE_A, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_position(BASE_UNUSED_HI, TALLY_MAX, TALLY_MAX, TALLY_MAX, TALLY_MAX,
                            TALLY_MAX, TALLY_MAX, TALLY_MAX, TALLY_MAX, TALLY_MAX,
                            TALLY_MAX, TALLY_MAX));
    // deletion wins with a wide tally
    send_item(make_position(BASE_A, 0, TALLY_MAX, 0, 0, 0, 0, 0, TALLY_MAX, 0, 0, 0));
    // winner equal to the base
    send_item(make_position(BASE_A, 0, 0, 5, 0, 0, 0, 0, 0, 0, 0, 5));
    send_item(make_position(BASE_C, 0, 0, 0, 9, 0, 0, 0, 0, 9, 0, 0));
    send_item(make_position(BASE_G, 0, 0, 0, 0, 9, 0, 0, 0, 0, 9, 0));
    send_item(make_position(BASE_T, 0, 1, 0, 0, 0, 8, 0, 0, 0, 0, 8));
    // base other or unused
    send_item(make_position(BASE_OTHER, 0, 0, 0, 5, 0, 0, 1, 0, 5, 0, 0));
    send_item(make_position(BASE_UNUSED_LO, 1, 0, 0, 0, 0, 7, 1, 0, 0, 7, 0));
    send_item(make_position(BASE_UNUSED_HI, 1, 0, 0, 0, 7, 0, 1, 0, 0, 0, 7));
    // one confirmation, maximum at the strength edge
    send_item(make_position(BASE_A, 1, 0, 0, 0, 0, 6, 1, 6, 0, 0, 0));
    // two confirmations block
    send_item(make_position(BASE_A, 2, 0, 0, 0, 0, 100, 2, 100, 0, 0, 0));
    // total of one and of two
    send_item(make_position(BASE_T, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0));
    send_item(make_position(BASE_A, 0, 0, 0, 2, 0, 0, 0, 0, 0, 2, 0));
    // ties and exact halves
    send_item(make_position(BASE_T, 0, 4, 4, 0, 0, 0, 0, 3, 3, 0, 0));
    send_item(make_position(BASE_T, 0, 0, 5, 2, 0, 0, 0, 0, 0, 2, 5));
    // wide one-confirmation decisions
    send_item(make_position(BASE_G, 1, 0, 0, 0, 0, TALLY_MAX, 1, 0, 0, TALLY_MAX, 0));
    settle();
  endtask

  // positions that sit on the haplotype threshold
  task automatic send_conflict_set();
    send_item(make_position(BASE_T, 0, 0, 5, 4, 0, 0, 0, 5, 4, 0, 0));
    send_item(make_position(BASE_A, 0, TALLY_MAX, 16'hfffe, 0, 0, 0, 0, 0, 0, TALLY_MAX,
                            16'hfffe));
    send_item(make_position(BASE_A, 0, 0, 0, 9, 1, 0, 0, 1, 0, 0, 9));
    settle();
  endtask

  task automatic test_haplo_registers();
    send_conflict_set();
    apply_settings(MIN_HAPLO_RESET, 1'b0);
    send_conflict_set();
    apply_settings(16'd0, 1'b1);
    send_conflict_set();
    apply_settings(16'hffff, 1'b1);
    send_conflict_set();
  endtask

  task automatic test_random_traffic();
    for (int blk = 0; blk < 8; blk++) begin
      case (blk)
        0:       apply_settings(MIN_HAPLO_RESET, HAPLO_ON_RESET);
        1:       apply_settings(16'd1, 1'b1);
        2:       apply_settings(16'hffff, 1'b1);
        3:       apply_settings(16'd0, 1'b0);
        4:       apply_settings(16'd2, 1'b1);
        5:       apply_settings(16'($urandom_range(65535)), 1'($urandom_range(1)));
        6:       apply_settings(16'd7, 1'b0);
        default: apply_settings(16'hffff, 1'b0);
      endcase
      case (blk / 2)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 71; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      repeat (BLOCK_ITEMS) send_item(random_position());
      settle();
    end
  endtask

  task automatic test_backpressure();
    apply_settings(MIN_HAPLO_RESET, HAPLO_ON_RESET);
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    repeat (64) send_item(random_position());
    settle();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    hold_req       = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    mismatches     = 0;
    positions_sent = 0;
    results_checked = 0;
    changes_seen   = 0;
    inserts_seen   = 0;
    settings_used  = 1;
    min_haplo_cfg  = MIN_HAPLO_RESET;
    haplo_on_cfg   = HAPLO_ON_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_haplo_registers();
    test_random_traffic();
    test_backpressure();
    settle();

    $display("covered %0d positions under %0d register settings, four traffic mixes",
             positions_sent, settings_used);
    $display("and a long result stall; %0d changes and %0d insertions emitted",
             changes_seen, inserts_seen);
    if (mismatches == 0 && decision_q.size() == 0) begin
      $display("base_vote_correction_decider: match");
    end else begin
      $display("base_vote_correction_decider: mismatch");
    end
    $finish;
  end

endmodule

// ===== base_vote_correction_decider.f =====
rtl/bvcd_pkg.sv
rtl/bvcd_cfg_regs.sv
rtl/bvcd_vote_eval.sv
rtl/base_vote_correction_decider.sv
tb/base_vote_correction_decider_tb.sv
